// ===== hw/rtl/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants of the triangle tile binner
// Fixed-point widths, configuration register codes and the job record that
// travels from the setup front end to the tile scanner.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int TILE_SHIFT  = 6;
  localparam int FRAC_BITS   = 4;
  localparam int RANGE_SHIFT = TILE_SHIFT + FRAC_BITS;

  localparam int COORD_W = 19;
  localparam int PID_W   = 16;
  localparam int CNT_W   = 4;
  localparam int VPP_W   = 2;
  localparam int IDX_W   = 6;

  localparam int MAX_TILES_X = 8;
  localparam int MAX_TILES_Y = 8;

  // edge coefficient widths
  localparam int EA_W    = COORD_W + 1;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int EC_W    = PROD_W + 1;
  localparam int TERM_W  = EA_W + CNT_W + 2;
  localparam int EVAL_W  = EC_W + 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILES_ACROSS = 2'd0,
    CFG_TILES_DOWN   = 2'd1,
    CFG_VERTS        = 2'd2
  } cfg_reg_e;

  localparam logic [CNT_W-1:0] TILES_ACROSS_RST = CNT_W'(8);
  localparam logic [CNT_W-1:0] TILES_DOWN_RST   = CNT_W'(8);
  localparam logic [VPP_W-1:0] VPP_TRIANGLE     = VPP_W'(3);
  localparam logic [VPP_W-1:0] VPP_RST          = VPP_TRIANGLE;

  typedef struct packed {
    logic [PID_W-1:0]           prim_id;
    logic                       is_tri;
    logic                       single;
    logic [CNT_W-1:0]           ntx;
    logic [CNT_W-1:0]           sx;
    logic [CNT_W-1:0]           ex;
    logic [CNT_W-1:0]           sy;
    logic [CNT_W-1:0]           ey;
    logic [IDX_W-1:0]           row_base;
    logic [2:0][EA_W-1:0]       ea;
    logic [2:0][EA_W-1:0]       eb;
    logic [2:0][EC_W-1:0]       ec;
  } job_t;

endpackage

// ===== hw/rtl/triangle_tile_binner.sv =====
// ----------------------------------------------------------------------------
// triangle_tile_binner: tile binning of one screen-space primitive
// Bins a line or triangle in signed 15.4 coordinates into 64-pixel tiles.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the vertices and prim_id_i and raise start; the item is taken at
//   an edge where start is high and busy is low. Configuration (tile
//   columns, tile rows, vertices per primitive) is written through
//   cfg_we_i / cfg_index_i / cfg_wdata_i while the block is idle.
//   Each kept tile appears for one cycle with valid_o high, in row-major
//   order; the final tile of a primitive has last_tile_o set. The receiver
//   cannot stall, results are never held.
// Sequence:
//   setup keeps busy high through its range step alone on an empty range,
//   through range and push steps for lines and single-tile primitives,
//   and through a multiply phase as well for triangles that span more than
//   one tile (one shared 19x19 multiplier builds the edge products in turn); busy
//   stays high longer while the two-entry job queue is full. The scanner
//   loads a job, visits each tile of the range in turn and, for ranges of
//   more than one tile, flushes the last kept tile.
// Reset:
//   clears all control state and the queue; registers return to 8 columns,
//   8 rows and triangles.
// ----------------------------------------------------------------------------
module triangle_tile_binner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we_i,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ttb_pkg::CNT_W-1:0]           cfg_wdata_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex0_x_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex0_y_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex1_x_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex1_y_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex2_x_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex2_y_i,
  input  logic [ttb_pkg::PID_W-1:0]           prim_id_i,
  output logic                                valid_o,
  output logic [ttb_pkg::IDX_W-1:0]           tile_index_o,
  output logic [ttb_pkg::PID_W-1:0]           prim_number_o,
  output logic                                last_tile_o
);
  import ttb_pkg::*;

  logic [CNT_W-1:0] tiles_across_q, tiles_down_q;
  logic [VPP_W-1:0] vpp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_across_q <= TILES_ACROSS_RST;
      tiles_down_q   <= TILES_DOWN_RST;
      vpp_q          <= VPP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TILES_ACROSS: tiles_across_q <= cfg_wdata_i;
        CFG_TILES_DOWN:   tiles_down_q   <= cfg_wdata_i;
        CFG_VERTS:        vpp_q          <= cfg_wdata_i[VPP_W-1:0];
        default:          ;
      endcase
    end
  end

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;

  ttb_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .tiles_across_i      (tiles_across_q),
    .tiles_down_i        (tiles_down_q),
    .vertices_per_prim_i (vpp_q),
    .vertex0_x_i         (vertex0_x_i),
    .vertex0_y_i         (vertex0_y_i),
    .vertex1_x_i         (vertex1_x_i),
    .vertex1_y_i         (vertex1_y_i),
    .vertex2_x_i         (vertex2_x_i),
    .vertex2_y_i         (vertex2_y_i),
    .prim_id_i           (prim_id_i),
    .job_valid_o         (fq_valid),
    .job_ready_i         (fq_ready),
    .job_o               (fq_job)
  );

  ttb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_job_i   (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_job_o    (qb_job)
  );

  ttb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (qb_valid),
    .job_ready_o   (qb_ready),
    .job_i         (qb_job),
    .valid_o       (valid_o),
    .tile_index_o  (tile_index_o),
    .prim_number_o (prim_number_o),
    .last_tile_o   (last_tile_o)
  );

endmodule

// ===== hw/rtl/ttb_front.sv =====
// ----------------------------------------------------------------------------
// ttb_front: primitive setup
// Takes one primitive, finds its clamped tile range and edge coefficients
// and queues a job for a non-empty range. C terms use one shared multiplier.
// ----------------------------------------------------------------------------
module ttb_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ttb_pkg::CNT_W-1:0]           tiles_across_i,
  input  logic [ttb_pkg::CNT_W-1:0]           tiles_down_i,
  input  logic [ttb_pkg::VPP_W-1:0]           vertices_per_prim_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex0_x_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex0_y_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex1_x_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex1_y_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex2_x_i,
  input  logic signed [ttb_pkg::COORD_W-1:0]  vertex2_y_i,
  input  logic [ttb_pkg::PID_W-1:0]           prim_id_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output ttb_pkg::job_t                       job_o
);
  import ttb_pkg::*;

  localparam int LT_W      = COORD_W - RANGE_SHIFT;
  localparam int HT_W      = COORD_W - RANGE_SHIFT + 1;
  localparam int MUL_STEPS = 6;
  localparam int STEP_W    = $clog2(MUL_STEPS + 1);

  typedef enum logic [1:0] {
    F_IDLE,
    F_RANGE,
    F_MUL,
    F_PUSH
  } front_state_e;

  front_state_e state_q;
  logic [STEP_W-1:0] step_q;

  logic signed [COORD_W-1:0] vx_q [3];
  logic signed [COORD_W-1:0] vy_q [3];
  logic [PID_W-1:0]          pid_q;
  job_t                      job_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [EC_W-1:0]    ec_q [3];

  // tile range helpers
  function automatic logic [CNT_W-1:0] lo_tile(input logic signed [COORD_W-1:0] v,
                                               input logic [CNT_W-1:0] cnt);
    logic [LT_W-1:0] t;
    t = v[COORD_W-1] ? '0 : v[COORD_W-1:RANGE_SHIFT];
    return (t < LT_W'(cnt)) ? t[CNT_W-1:0] : cnt;
  endfunction

  function automatic logic [CNT_W-1:0] hi_tile(input logic signed [COORD_W-1:0] v,
                                               input logic [CNT_W-1:0] cnt);
    logic [COORD_W-1:0] u;
    logic [COORD_W:0]   s;
    logic [HT_W-1:0]    t;
    u = v[COORD_W-1] ? '0 : v;
    s = {1'b0, u} + (COORD_W+1)'((1 << RANGE_SHIFT) - 1);
    t = s[COORD_W:RANGE_SHIFT] + HT_W'(1);
    return (t < HT_W'(cnt)) ? t[CNT_W-1:0] : cnt;
  endfunction

  // range and edge setup, evaluated in F_RANGE
  logic [CNT_W-1:0]          ntx, nty, sx, ex, sy, ey;
  logic                      is_tri, single, empty;
  logic signed [COORD_W-1:0] xmin, xmax, ymin, ymax;
  logic [2*CNT_W-1:0]        row_prod;
  job_t                      job_d;

  always_comb begin
    ntx    = (tiles_across_i > CNT_W'(MAX_TILES_X)) ? CNT_W'(MAX_TILES_X) : tiles_across_i;
    nty    = (tiles_down_i > CNT_W'(MAX_TILES_Y)) ? CNT_W'(MAX_TILES_Y) : tiles_down_i;
    is_tri = (vertices_per_prim_i == VPP_TRIANGLE);
    xmin = vx_q[0];
    xmax = vx_q[0];
    ymin = vy_q[0];
    ymax = vy_q[0];
    if (vx_q[1] < xmin) xmin = vx_q[1];
    if (vx_q[1] > xmax) xmax = vx_q[1];
    if (vy_q[1] < ymin) ymin = vy_q[1];
    if (vy_q[1] > ymax) ymax = vy_q[1];
    if (is_tri && vx_q[2] < xmin) xmin = vx_q[2];
    if (is_tri && vx_q[2] > xmax) xmax = vx_q[2];
    if (is_tri && vy_q[2] < ymin) ymin = vy_q[2];
    if (is_tri && vy_q[2] > ymax) ymax = vy_q[2];
    sx = lo_tile(xmin, ntx);
    sy = lo_tile(ymin, nty);
    ex = hi_tile(xmax, ntx);
    ey = hi_tile(ymax, nty);
    single   = (({1'b0, sx} + (CNT_W+1)'(1)) == {1'b0, ex}) &&
               (({1'b0, sy} + (CNT_W+1)'(1)) == {1'b0, ey});
    empty    = (sx >= ex) || (sy >= ey);
    row_prod = sy * ntx;

    job_d          = job_q;
    job_d.prim_id  = pid_q;
    job_d.is_tri   = is_tri;
    job_d.single   = single;
    job_d.ntx      = ntx;
    job_d.sx       = sx;
    job_d.ex       = ex;
    job_d.sy       = sy;
    job_d.ey       = ey;
    job_d.row_base = row_prod[IDX_W-1:0];
    for (int i = 0; i < 3; i++) begin
      job_d.ea[i] = EA_W'(vy_q[(i+1)%3]) - EA_W'(vy_q[i]);
      job_d.eb[i] = EA_W'(vx_q[(i+1)%3]) - EA_W'(vx_q[i]);
    end
  end

  // operand select for the shared multiplier: C = y1*x0 - x1*y0 per edge
  logic signed [COORD_W-1:0] mul_a, mul_b;
  logic [STEP_W-1:0]         prd_idx;
  logic [1:0]                prd_edge;

  always_comb begin
    unique case (step_q)
      STEP_W'(0): begin mul_a = vy_q[1]; mul_b = vx_q[0]; end
      STEP_W'(1): begin mul_a = vx_q[1]; mul_b = vy_q[0]; end
      STEP_W'(2): begin mul_a = vy_q[2]; mul_b = vx_q[1]; end
      STEP_W'(3): begin mul_a = vx_q[2]; mul_b = vy_q[1]; end
      STEP_W'(4): begin mul_a = vy_q[0]; mul_b = vx_q[2]; end
      STEP_W'(5): begin mul_a = vx_q[0]; mul_b = vy_q[2]; end
      default:    begin mul_a = '0;      mul_b = '0;      end
    endcase
    prd_idx  = step_q - STEP_W'(1);
    prd_edge = prd_idx[2:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (start) state_q <= F_RANGE;
        end
        F_RANGE: begin
          step_q <= '0;
          priority if (empty)         state_q <= F_IDLE;
          else if (is_tri && !single) state_q <= F_MUL;
          else                        state_q <= F_PUSH;
        end
        F_MUL: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(MUL_STEPS)) state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start) begin
      vx_q[0] <= vertex0_x_i;
      vy_q[0] <= vertex0_y_i;
      vx_q[1] <= vertex1_x_i;
      vy_q[1] <= vertex1_y_i;
      vx_q[2] <= vertex2_x_i;
      vy_q[2] <= vertex2_y_i;
      pid_q   <= prim_id_i;
    end
    if (state_q == F_RANGE) job_q <= job_d;
    if (state_q == F_MUL) begin
      prod_q <= mul_a * mul_b;
      if (step_q != '0) begin
        ec_q[prd_edge] <= prd_idx[0] ? (ec_q[prd_edge] - EC_W'(prod_q)) : EC_W'(prod_q);
      end
    end
  end

  always_comb begin
    job_o = job_q;
    for (int i = 0; i < 3; i++) job_o.ec[i] = ec_q[i];
  end

  assign job_valid_o = (state_q == F_PUSH);
  assign busy        = (state_q != F_IDLE);

endmodule

// ===== hw/rtl/ttb_queue.sv =====
// ----------------------------------------------------------------------------
// ttb_queue: job queue
// Short first-in first-out buffer of job records between setup and scan.
// ----------------------------------------------------------------------------
module ttb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ttb_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ttb_pkg::job_t pop_job_o
);
  import ttb_pkg::*;

  job_t               q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != (Q_PTR_W+1)'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= push_job_i;
  end

endmodule

// ===== hw/rtl/ttb_back.sv =====
// ----------------------------------------------------------------------------
// ttb_back: tile scanner
// Walks the tile range of one job in row-major order, one tile per cycle,
// runs the edge tests on multi-tile triangles and emits the kept tiles. One
// kept tile is held back so that the final one can carry the last flag.
// ----------------------------------------------------------------------------
module ttb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  ttb_pkg::job_t               job_i,
  output logic                        valid_o,
  output logic [ttb_pkg::IDX_W-1:0]   tile_index_o,
  output logic [ttb_pkg::PID_W-1:0]   prim_number_o,
  output logic                        last_tile_o
);
  import ttb_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FLUSH
  } back_state_e;

  back_state_e      state_q;
  job_t             job_q;
  logic [CNT_W-1:0] x_q, y_q;
  logic [IDX_W:0]   row_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;

  logic [IDX_W-1:0] cur_idx;
  logic [2:0]       reject;
  logic             keep, x_last, y_last;

  // edge functions at the corner each edge selects
  always_comb begin
    logic signed [EA_W-1:0]   ea_s, eb_s;
    logic signed [EC_W-1:0]   ec_s;
    logic [CNT_W-1:0]         cx, cy;
    logic signed [TERM_W-1:0] tx, ty, diff;
    logic signed [EVAL_W-1:0] ev;
    for (int i = 0; i < 3; i++) begin
      ea_s = $signed(job_q.ea[i]);
      eb_s = $signed(job_q.eb[i]);
      ec_s = $signed(job_q.ec[i]);
      cx   = (ea_s <= 0) ? (x_q + CNT_W'(1)) : x_q;
      cy   = (eb_s > 0) ? (y_q + CNT_W'(1)) : y_q;
      tx   = $signed({1'b0, cx}) * ea_s;
      ty   = $signed({1'b0, cy}) * eb_s;
      diff = tx - ty;
      ev   = (EVAL_W'(diff) <<< RANGE_SHIFT) - EVAL_W'(ec_s);
      reject[i] = !ev[EVAL_W-1] && (ev != '0);
    end
  end

  assign keep        = !job_q.is_tri || (reject == '0);
  assign cur_idx     = row_q[IDX_W-1:0] + IDX_W'(x_q);
  assign x_last      = (({1'b0, x_q} + (CNT_W+1)'(1)) == {1'b0, job_q.ex});
  assign y_last      = (({1'b0, y_q} + (CNT_W+1)'(1)) == {1'b0, job_q.ey});
  assign job_ready_o = (state_q == B_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= B_IDLE;
      valid_o       <= 1'b0;
      tile_index_o  <= '0;
      prim_number_o <= '0;
      last_tile_o   <= 1'b0;
      pend_q        <= 1'b0;
      pend_idx_q    <= '0;
      x_q           <= '0;
      y_q           <= '0;
      row_q         <= '0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            x_q     <= job_i.sx;
            y_q     <= job_i.sy;
            row_q   <= (IDX_W+1)'(job_i.row_base);
            state_q <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (job_q.single) begin
            valid_o       <= 1'b1;
            tile_index_o  <= cur_idx;
            prim_number_o <= job_q.prim_id;
            last_tile_o   <= 1'b1;
            state_q       <= B_IDLE;
          end else begin
            if (keep) begin
              // the held tile is not the last one: send it now
              if (pend_q) begin
                valid_o       <= 1'b1;
                tile_index_o  <= pend_idx_q;
                prim_number_o <= job_q.prim_id;
                last_tile_o   <= 1'b0;
              end
              pend_q     <= 1'b1;
              pend_idx_q <= cur_idx;
            end
            if (x_last) begin
              x_q   <= job_q.sx;
              y_q   <= y_q + CNT_W'(1);
              row_q <= row_q + (IDX_W+1)'(job_q.ntx);
              if (y_last) state_q <= B_FLUSH;
            end else begin
              x_q <= x_q + CNT_W'(1);
            end
          end
        end
        B_FLUSH: begin
          if (pend_q) begin
            valid_o       <= 1'b1;
            tile_index_o  <= pend_idx_q;
            prim_number_o <= job_q.prim_id;
            last_tile_o   <= 1'b1;
          end
          pend_q  <= 1'b0;
          state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && job_valid_i) job_q <= job_i;
  end

endmodule

// ===== hw/rtl/ttb_checker.sv =====
// ----------------------------------------------------------------------------
// ttb_checker: port-level checks of the tile binner
// Watches the command and result ports and checks the order of results.
// ----------------------------------------------------------------------------
module ttb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        valid_o,
  input logic [ttb_pkg::IDX_W-1:0]   tile_index_o,
  input logic [ttb_pkg::PID_W-1:0]   prim_number_o,
  input logic                        last_tile_o
);
  import ttb_pkg::*;

  logic             open_q, seen_q;
  logic [PID_W-1:0] pid_q;
  logic [IDX_W-1:0] idx_q;

  // open: a primitive has sent tiles but not its last one yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      seen_q <= 1'b0;
      pid_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (start && !busy) seen_q <= 1'b1;
      if (valid_o) begin
        open_q <= !last_tile_o;
        pid_q  <= prim_number_o;
        idx_q  <= tile_index_o;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && open_q) |-> (prim_number_o == pid_q))
    else $error("primitive number changed before its last tile");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && open_q) |-> (tile_index_o > idx_q))
    else $error("tiles of one primitive not in row-major order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> seen_q)
    else $error("result without any item taken");

endmodule

bind triangle_tile_binner ttb_checker u_ttb_checker (.*);

// ===== tb/tb_triangle_tile_binner.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_tile_binner: self-checking bench for the triangle tile binner
// Feeds lines and triangles under several tile grid settings, predicts the
// kept tiles of every accepted primitive and checks each emitted tile in order.
// ----------------------------------------------------------------------------
module tb_triangle_tile_binner;
  import ttb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam int N_SETTINGS = 10;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
  } prim_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [PID_W-1:0] pid;
    logic             last;
  } tile_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CNT_W-1:0]          cfg_wdata_i = '0;
  logic signed [COORD_W-1:0] vertex0_x_i = '0;
  logic signed [COORD_W-1:0] vertex0_y_i = '0;
  logic signed [COORD_W-1:0] vertex1_x_i = '0;
  logic signed [COORD_W-1:0] vertex1_y_i = '0;
  logic signed [COORD_W-1:0] vertex2_x_i = '0;
  logic signed [COORD_W-1:0] vertex2_y_i = '0;
  logic [PID_W-1:0]          prim_id_i = '0;
  logic                      valid_o;
  logic [IDX_W-1:0]          tile_index_o;
  logic [PID_W-1:0]          prim_number_o;
  logic                      last_tile_o;

  // shadow of the binner registers
  logic [CNT_W-1:0] cols_cfg = TILES_ACROSS_RST;
  logic [CNT_W-1:0] rows_cfg = TILES_DOWN_RST;
  logic [VPP_W-1:0] verts_cfg = VPP_RST;

  prim_t prims_pending[$];
  tile_t tiles_due[$];
  prim_t next_prim;
  int    prims_sent = 0;
  int    prims_taken = 0;
  int    tile_errors = 0;
  int    send_idle_pct = 36;

  logic [CNT_W-1:0] set_cols [N_SETTINGS] = '{8, 15, 1, 5, 0, 3, 8, 2, 6, 8};
  logic [CNT_W-1:0] set_rows [N_SETTINGS] = '{8, 12, 1, 3, 4, 0, 8, 7, 8, 1};
  logic [CNT_W-1:0] set_verts [N_SETTINGS] = '{4'b0011, 4'b0111, 4'b0011, 4'b1110,
                                               4'b0011, 4'b1101, 4'b1100, 4'b0011,
                                               4'b1011, 4'b0011};

  triangle_tile_binner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .vertex0_x_i   (vertex0_x_i),
    .vertex0_y_i   (vertex0_y_i),
    .vertex1_x_i   (vertex1_x_i),
    .vertex1_y_i   (vertex1_y_i),
    .vertex2_x_i   (vertex2_x_i),
    .vertex2_y_i   (vertex2_y_i),
    .prim_id_i     (prim_id_i),
    .valid_o       (valid_o),
    .tile_index_o  (tile_index_o),
    .prim_number_o (prim_number_o),
    .last_tile_o   (last_tile_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint tile_floor(longint v, longint cnt);
    longint t;
    t = (v < 0) ? 0 : (v >>> RANGE_SHIFT);
    return (t < cnt) ? t : cnt;
  endfunction

  // one past the covering tile, plus a guard column or row
  function automatic longint tile_ceil_pad(longint v, longint cnt);
    longint t;
    t = (v < 0) ? 1 : (((v + (longint'(1) <<< RANGE_SHIFT) - 1) >>> RANGE_SHIFT) + 1);
    return (t < cnt) ? t : cnt;
  endfunction

  // works out the tiles a primitive lands in and queues them
  function automatic void bin_prim(prim_t p);
    longint px[3], py[3], ea[3], eb[3], ec[3];
    longint ntx, nty, xmin, xmax, ymin, ymax, sx, sy, ex, ey, cx, cy;
    int     nv, j;
    bit     is_triangle, keep;
    tile_t  t;
    tile_t  kept[$];
    is_triangle = (verts_cfg == VPP_TRIANGLE);
    ntx = (cols_cfg > MAX_TILES_X) ? MAX_TILES_X : cols_cfg;
    nty = (rows_cfg > MAX_TILES_Y) ? MAX_TILES_Y : rows_cfg;
    nv = is_triangle ? 3 : 2;
    px[0] = $signed(p.x0);
    py[0] = $signed(p.y0);
    px[1] = $signed(p.x1);
    py[1] = $signed(p.y1);
    px[2] = $signed(p.x2);
    py[2] = $signed(p.y2);
    xmin = px[0];
    xmax = px[0];
    ymin = py[0];
    ymax = py[0];
    for (int i = 1; i < nv; i++) begin
      if (px[i] < xmin) xmin = px[i];
      if (px[i] > xmax) xmax = px[i];
      if (py[i] < ymin) ymin = py[i];
      if (py[i] > ymax) ymax = py[i];
    end
    sx = tile_floor(xmin, ntx);
    sy = tile_floor(ymin, nty);
    ex = tile_ceil_pad(xmax, ntx);
    ey = tile_ceil_pad(ymax, nty);

    // a one-tile range skips the edge test
    if (sx + 1 == ex && sy + 1 == ey) begin
      t.idx = IDX_W'(sy * ntx + sx);
      t.pid = p.pid;
      t.last = 1'b1;
      tiles_due.insert(tiles_due.size(), t);
      return;
    end

    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      ea[i] = py[j] - py[i];
      eb[i] = px[j] - px[i];
      ec[i] = py[j] * px[i] - px[j] * py[i];
    end

    for (longint y = sy; y < ey; y++) begin
      for (longint x = sx; x < ex; x++) begin
        keep = 1'b1;
        if (is_triangle) begin
          for (int e = 0; e < 3; e++) begin
            // corner picked by the edge direction
            cx = (ea[e] <= 0) ? x + 1 : x;
            cy = (eb[e] > 0) ? y + 1 : y;
            if ((cx <<< RANGE_SHIFT) * ea[e] - (cy <<< RANGE_SHIFT) * eb[e] - ec[e] > 0)
              keep = 1'b0;
          end
        end
        if (keep) begin
          t.idx = IDX_W'(y * ntx + x);
          t.pid = p.pid;
          t.last = 1'b0;
          kept.insert(kept.size(), t);
        end
      end
    end
    if (kept.size() > 0) kept[kept.size() - 1].last = 1'b1;
    foreach (kept[k]) tiles_due.insert(tiles_due.size(), kept[k]);
  endfunction

  function automatic logic [COORD_W-1:0] near(int ctr, int span);
    return COORD_W'(ctr + int'($urandom_range(2 * span)) - span);
  endfunction

  // mostly clustered vertices of mixed size, some fully random
  function automatic prim_t random_prim();
    prim_t       p;
    int          span, ctr_x, ctr_y;
    int unsigned mode;
    mode = $urandom_range(9);
    p.pid = PID_W'($urandom);
    if (mode == 0) begin
      p.x0 = COORD_W'($urandom);
      p.y0 = COORD_W'($urandom);
      p.x1 = COORD_W'($urandom);
      p.y1 = COORD_W'($urandom);
      p.x2 = COORD_W'($urandom);
      p.y2 = COORD_W'($urandom);
    end else begin
      span = (mode < 4) ? 300 : (mode < 8) ? 2500 : 9000;
      ctr_x = int'($urandom_range(11000)) - 1500;
      ctr_y = int'($urandom_range(11000)) - 1500;
      p.x0 = near(ctr_x, span);
      p.y0 = near(ctr_y, span);
      p.x1 = near(ctr_x, span);
      p.y1 = near(ctr_y, span);
      p.x2 = near(ctr_x, span);
      p.y2 = near(ctr_y, span);
    end
    return p;
  endfunction

  task automatic push_prim(int x0, int y0, int x1, int y1, int x2, int y2, int pid);
    prim_t p;
    p = {PID_W'(pid), COORD_W'(x0), COORD_W'(y0), COORD_W'(x1), COORD_W'(y1),
         COORD_W'(x2), COORD_W'(y2)};
    prims_pending.insert(prims_pending.size(), p);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_TILES_ACROSS: cols_cfg = val;
      CFG_TILES_DOWN:   rows_cfg = val;
      CFG_VERTS:        verts_cfg = val[VPP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_binner(logic [CNT_W-1:0] cols, logic [CNT_W-1:0] rows,
                                logic [CNT_W-1:0] verts);
    write_reg(CFG_TILES_ACROSS, cols);
    write_reg(CFG_TILES_DOWN, rows);
    write_reg(CFG_VERTS, verts);
    write_reg(CFG_SPARE, CNT_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // all items taken, all tiles seen, then room for empty jobs still in flight
  task automatic wait_idle();
    while (prims_pending.size() != 0 || prims_sent != prims_taken || tiles_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && prims_sent == prims_taken) begin
      if (prims_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_prim = prims_pending.pop_front();
        prim_id_i <= next_prim.pid;
        vertex0_x_i <= next_prim.x0;
        vertex0_y_i <= next_prim.y0;
        vertex1_x_i <= next_prim.x1;
        vertex1_y_i <= next_prim.y1;
        vertex2_x_i <= next_prim.x2;
        vertex2_y_i <= next_prim.y2;
        start <= 1'b1;
        prims_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    tile_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        bin_prim({prim_id_i, vertex0_x_i, vertex0_y_i, vertex1_x_i, vertex1_y_i,
                  vertex2_x_i, vertex2_y_i});
        prims_taken++;
      end
      if (valid_o) begin
        if (tiles_due.size() == 0) begin
          $error("unexpected tile: tile_index %0d prim_number %0d last_tile %0d",
                 tile_index_o, prim_number_o, last_tile_o);
          tile_errors++;
        end else begin
          want = tiles_due.pop_front();
          if (tile_index_o !== want.idx) begin
            $error("tile_index: expected %0d, got %0d", want.idx, tile_index_o);
            tile_errors++;
          end
          if (prim_number_o !== want.pid) begin
            $error("prim_number: expected %0d, got %0d", want.pid, prim_number_o);
            tile_errors++;
          end
          if (last_tile_o !== want.last) begin
            $error("last_tile: expected %0d, got %0d", want.last, last_tile_o);
            tile_errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // triangles at the reset grid
    push_prim(0, 0, 0, 0, 0, 0, 0);
    push_prim(262143, 262143, 262143, 262143, 262143, 262143, 65535);
    push_prim(-262144, -262144, -262144, -262144, -262144, -262144, 1);
    push_prim(0, 0, 8191, 0, 0, 8191, 2);
    push_prim(0, 0, 0, 8191, 8191, 0, 3);
    push_prim(3000, 3000, 3300, 3050, 3100, 3400, 4);
    push_prim(3000, 3000, 3100, 3400, 3300, 3050, 5);
    push_prim(1000, 1000, 5000, 5000, 3000, 3000, 6);
    push_prim(-3000, -2000, 4000, 500, 1000, 6000, 7);
    push_prim(-262144, 262143, 262143, -262144, 0, 0, 8);
    push_prim(7168, 7168, 7168, 7168, 7168, 7168, 16'hA5A5);
    push_prim(7500, 7500, 8100, 7600, 7700, 8150, 16'h5A5A);
    push_prim(0, 4000, 8191, 4010, 0, 4020, 9);
    wait_idle();

    // lines, third vertex is don't-care
    program_binner(4'd8, 4'd8, 4'b1110);
    push_prim(0, 0, 8191, 8191, -262144, 262143, 10);
    push_prim(500, 3000, 7000, 3000, 262143, -262144, 11);
    push_prim(2048, 2048, 2048, 2048, 0, 0, 12);
    push_prim(-5000, 1000, 1500, -200, 4000, 4000, 13);
    push_prim(262143, -262144, -262144, 262143, 0, 0, 14);
    wait_idle();

    for (int s = 0; s < N_SETTINGS; s++) begin
      send_idle_pct = (s < 4) ? 36 : (s < 7) ? 70 : 0;
      program_binner(set_cols[s], set_rows[s], set_verts[s]);
      // a zero-sized grid emits nothing, keep those batches short
      repeat ((set_cols[s] == 0 || set_rows[s] == 0) ? 4 : 13)
        prims_pending.insert(prims_pending.size(), random_prim());
      wait_idle();
    end

    if (tile_errors == 0 && tiles_due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
